FILE: rtl/core/pdre_pkg.sv
package pdre_pkg;

	// width of each configuration register field
	localparam int CFG_W = 13;
	// width of the configuration register index
	localparam int CFG_IDX_W = 3;

	// register reset values
	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 13'd640;
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;
	localparam logic [CFG_W-1:0] MAX_DIM_RST      = 13'd0;
	localparam logic             BYTE_ORDER_RST   = 1'b0;

	// configuration register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 3'd0,
		REG_FRAME_HEIGHT = 3'd1,
		REG_MAX_DIM      = 3'd2,
		REG_BYTE_ORDER   = 3'd3
	} cfg_reg_t;

	// keep decision for one item
	typedef struct packed {
		logic keep;
		logic row_end;
		logic frame_end;
	} keep_flags_t;

endpackage

FILE: rtl/core/pdre_cfg.sv
module pdre_cfg #(
	parameter int MAX_SIDE = 4096,
	localparam int SW = $clog2(MAX_SIDE + 1),
	localparam int PW = 2 * SW
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [pdre_pkg::CFG_IDX_W-1:0] wr_index,
	input  logic [pdre_pkg::CFG_W-1:0]     wr_data,
	output logic                           busy,
	output logic                           byte_order,
	output logic [SW-1:0]                  side_w,
	output logic [SW-1:0]                  side_h,
	output logic [SW-1:0]                  num,
	output logic [SW-1:0]                  den,
	output logic [PW-1:0]                  col_limit,
	output logic [PW-1:0]                  row_limit
);
	import pdre_pkg::*;

	localparam int CW = (CFG_W > SW) ? CFG_W : SW;
	localparam logic [CW-1:0] MAX_X = CW'(MAX_SIDE);

	logic [CFG_W-1:0] frame_width_q;
	logic [CFG_W-1:0] frame_height_q;
	logic [CFG_W-1:0] max_dim_q;
	logic             byte_order_q;
	logic [1:0]       settle_q;

	logic [CW-1:0] fw_x, fh_x, md_x;
	logic [SW-1:0] w_c, h_c, d_c, m_c, num_c, den_c;
	logic          scale_c;

	logic [SW-1:0] w_q, h_q, num_q, den_q;
	logic [PW-1:0] col_limit_q, row_limit_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= FRAME_WIDTH_RST;
			frame_height_q <= FRAME_HEIGHT_RST;
			max_dim_q      <= MAX_DIM_RST;
			byte_order_q   <= BYTE_ORDER_RST;
		end else if (wr_en) begin
			case (cfg_reg_t'(wr_index))
				REG_FRAME_WIDTH:  frame_width_q  <= wr_data;
				REG_FRAME_HEIGHT: frame_height_q <= wr_data;
				REG_MAX_DIM:      max_dim_q      <= wr_data;
				REG_BYTE_ORDER:   byte_order_q   <= wr_data[0];
				default: ;
			endcase
		end
	end

	// busy stays high while derived values settle after reset or a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= 2'd2;
		end else if (wr_en) begin
			settle_q <= 2'd2;
		end else if (settle_q != 2'd0) begin
			settle_q <= settle_q - 2'd1;
		end
	end

	// clamp sides and pick the scale ratio
	always_comb begin
		fw_x = CW'(frame_width_q);
		fh_x = CW'(frame_height_q);
		md_x = CW'(max_dim_q);
		w_c = (fw_x == '0) ? SW'(1) : ((fw_x > MAX_X) ? SW'(MAX_SIDE) : SW'(fw_x));
		h_c = (fh_x == '0) ? SW'(1) : ((fh_x > MAX_X) ? SW'(MAX_SIDE) : SW'(fh_x));
		d_c = (md_x > MAX_X) ? SW'(MAX_SIDE) : SW'(md_x);
		m_c = (w_c > h_c) ? w_c : h_c;
		scale_c = (d_c != '0) && (m_c > d_c);
		num_c = scale_c ? m_c : SW'(1);
		den_c = scale_c ? d_c : SW'(1);
	end

	// first stage: clamped sides and ratio
	always_ff @(posedge clk) begin
		w_q   <= w_c;
		h_q   <= h_c;
		num_q <= num_c;
		den_q <= den_c;
	end

	// second stage: scaled side limits
	always_ff @(posedge clk) begin
		col_limit_q <= PW'(w_q) * PW'(den_q);
		row_limit_q <= PW'(h_q) * PW'(den_q);
	end

	assign busy       = (settle_q != 2'd0);
	assign byte_order = byte_order_q;
	assign side_w     = w_q;
	assign side_h     = h_q;
	assign num        = num_q;
	assign den        = den_q;
	assign col_limit  = col_limit_q;
	assign row_limit  = row_limit_q;

endmodule

FILE: rtl/core/pdre_keep.sv
module pdre_keep #(
	parameter int MAX_SIDE = 4096,
	localparam int SW = $clog2(MAX_SIDE + 1),
	localparam int PW = 2 * SW,
	localparam int AW = PW + 2
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  frame_start,
	input  logic [SW-1:0]         side_w,
	input  logic [SW-1:0]         side_h,
	input  logic [SW-1:0]         num,
	input  logic [SW-1:0]         den,
	input  logic [PW-1:0]         col_limit,
	input  logic [PW-1:0]         row_limit,
	output pdre_pkg::keep_flags_t flags
);
	import pdre_pkg::*;

	logic [SW-1:0] col_q, row_q;
	logic [AW-1:0] col_pos_q, col_next_q, row_pos_q, row_next_q;

	logic [SW-1:0] col_c, row_c, col_inc, row_inc;
	logic [AW-1:0] col_pos_c, col_next_c, row_pos_c, row_next_c;
	logic [AW-1:0] num_x, num2_x, den_x, climit_x, rlimit_x;
	logic          col_keep, row_keep;

	logic [SW-1:0] col_n, row_n;
	logic [AW-1:0] col_pos_n, col_next_n, row_pos_n, row_next_n;

	// position seen by this item, frame start clears it
	always_comb begin
		col_c      = frame_start ? '0 : col_q;
		row_c      = frame_start ? '0 : row_q;
		col_pos_c  = frame_start ? '0 : col_pos_q;
		col_next_c = frame_start ? '0 : col_next_q;
		row_pos_c  = frame_start ? '0 : row_pos_q;
		row_next_c = frame_start ? '0 : row_next_q;
	end

	// keep decision and end markers
	always_comb begin
		num_x    = AW'(num);
		num2_x   = AW'({num, 1'b0});
		den_x    = AW'(den);
		climit_x = AW'(col_limit);
		rlimit_x = AW'(row_limit);
		col_keep = (col_next_c < col_pos_c + den_x) && (col_next_c + num_x <= climit_x);
		row_keep = (row_next_c < row_pos_c + den_x) && (row_next_c + num_x <= rlimit_x);
		flags.keep      = col_keep && row_keep;
		flags.row_end   = (col_next_c + num2_x > climit_x);
		flags.frame_end = flags.row_end && (row_next_c + num2_x > rlimit_x);
	end

	// next position
	always_comb begin
		col_inc    = col_c + SW'(1);
		row_inc    = row_c + SW'(1);
		col_n      = col_inc;
		col_pos_n  = col_pos_c + den_x;
		col_next_n = col_keep ? col_next_c + num_x : col_next_c;
		row_n      = row_c;
		row_pos_n  = row_pos_c;
		row_next_n = row_next_c;
		if (col_inc >= side_w) begin
			col_n      = '0;
			col_pos_n  = '0;
			col_next_n = '0;
			row_n      = row_inc;
			row_pos_n  = row_pos_c + den_x;
			row_next_n = row_keep ? row_next_c + num_x : row_next_c;
			if (row_inc >= side_h) begin
				row_n      = '0;
				row_pos_n  = '0;
				row_next_n = '0;
			end
		end
	end

	// position registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q      <= '0;
			row_q      <= '0;
			col_pos_q  <= '0;
			col_next_q <= '0;
			row_pos_q  <= '0;
			row_next_q <= '0;
		end else if (en) begin
			col_q      <= col_n;
			row_q      <= row_n;
			col_pos_q  <= col_pos_n;
			col_next_q <= col_next_n;
			row_pos_q  <= row_pos_n;
			row_next_q <= row_next_n;
		end
	end

	ast_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		en |=> (col_q < side_w) || $changed(side_w))
		else $error("column position not wrapped at row end");

	ast_scaled_order: assert property (@(posedge clk) disable iff (!arst_n)
		$past(en) && !$past(frame_start) && (col_q != '0) && $stable(den)
		|-> col_pos_q == $past(col_pos_q) + AW'(den))
		else $error("column scaled position not advanced by one step");

	ast_end_implies_row: assert property (@(posedge clk) disable iff (!arst_n)
		flags.frame_end |-> flags.row_end)
		else $error("frame end without row end");

endmodule

FILE: rtl/core/pixel_downscale_rgb_extract.sv
// Nearest-neighbor downscaler with RGB extraction for a raster stream of
// three-byte pixels. One item is accepted per clock cycle while in_stall is
// low. A kept pixel passes the input register, then the result register,
// which holds it while out_stall is high; dropped pixels give no output
// item. The keep decision for each pixel is a set of parallel add-and-compare
// steps on running column and row accumulators, so the rate is one item per
// cycle when nothing stalls. After reset and after every configuration write
// the input stalls while the clamped sides, the scale ratio and the side
// limits (one registered multiply) settle. The user must write configuration
// only while idle; the block itself does not enforce it.
module pixel_downscale_rgb_extract #(
	parameter int MAX_SIDE = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [pdre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pdre_pkg::CFG_W-1:0]     cfg_data,
	// source pixels
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     byte_zero,
	input  logic [7:0]                     byte_one,
	input  logic [7:0]                     byte_two,
	input  logic                           frame_start,
	// kept pixels
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic                           row_end,
	output logic                           frame_end
);
	import pdre_pkg::*;

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int PW = 2 * SW;

	logic          cfg_busy, byte_order;
	logic [SW-1:0] side_w, side_h, num, den;
	logic [PW-1:0] col_limit, row_limit;

	logic       valid_s1;
	logic [7:0] byte_zero_s1, byte_one_s1, byte_two_s1;
	logic       frame_start_s1;

	logic        proc_en, step_en;
	keep_flags_t flags;

	logic       out_valid_s2;
	logic [7:0] red_s2, green_s2, blue_s2;
	logic       row_end_s2, frame_end_s2;

	assign cfg_ready = 1'b1;

	pdre_cfg #(.MAX_SIDE(MAX_SIDE)) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr_en      (cfg_valid && cfg_ready),
		.wr_index   (cfg_index),
		.wr_data    (cfg_data),
		.busy       (cfg_busy),
		.byte_order (byte_order),
		.side_w     (side_w),
		.side_h     (side_h),
		.num        (num),
		.den        (den),
		.col_limit  (col_limit),
		.row_limit  (row_limit)
	);

	// s1 item moves on when the result register is free or being taken
	assign proc_en  = !out_valid_s2 || !out_stall;
	assign step_en  = valid_s1 && proc_en;
	assign in_stall = cfg_busy || (valid_s1 && !proc_en);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end else if (proc_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_zero_s1   <= byte_zero;
			byte_one_s1    <= byte_one;
			byte_two_s1    <= byte_two;
			frame_start_s1 <= frame_start;
		end
	end

	pdre_keep #(.MAX_SIDE(MAX_SIDE)) u_keep (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (step_en),
		.frame_start (frame_start_s1),
		.side_w      (side_w),
		.side_h      (side_h),
		.num         (num),
		.den         (den),
		.col_limit   (col_limit),
		.row_limit   (row_limit),
		.flags       (flags)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (proc_en) begin
			out_valid_s2 <= valid_s1 && flags.keep;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en && flags.keep) begin
			red_s2       <= byte_order ? byte_two_s1 : byte_zero_s1;
			green_s2     <= byte_one_s1;
			blue_s2      <= byte_order ? byte_zero_s1 : byte_two_s1;
			row_end_s2   <= flags.row_end;
			frame_end_s2 <= flags.frame_end;
		end
	end

	assign out_valid = out_valid_s2;
	assign red       = red_s2;
	assign green     = green_s2;
	assign blue      = blue_s2;
	assign row_end   = row_end_s2;
	assign frame_end = frame_end_s2;

	ast_cfg_settle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> in_stall)
		else $error("item taken before configuration settled");

	ast_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !proc_en |=> valid_s1)
		else $error("item lost from input register");

	ast_s1_load: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> valid_s1)
		else $error("accepted item missing from input register");

	ast_out_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 && frame_end_s2 |-> row_end_s2)
		else $error("frame end marked without row end");

endmodule
